// ===== rtl/hrm_pkg.sv =====
package hrm_pkg;

  localparam int unsigned BATCH_DEPTH_DEF = 9;

  // BPM divider geometry: numerator width equals the iteration count
  localparam int unsigned NUM_W     = 17;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned IBI_W     = 16;
  localparam int unsigned RR_W      = 16;
  localparam int unsigned BYTE_W    = 8;

  // (1024*ibi + 500) / 1000 == (128*ibi + 62) / 125; the divide by 125 is a
  // reciprocal multiply, exact for numerators below 2^23
  localparam int unsigned RR_NUM_W   = 23;
  localparam int unsigned RR_RECIP_W = 24;
  localparam int unsigned RR_PROD_W  = RR_NUM_W + RR_RECIP_W;
  localparam int unsigned RR_SHIFT   = 30;

  localparam logic [16:0]  MS_PER_MIN    = 17'd60000;
  localparam logic [22:0]  RR_ROUND_Q    = 23'd62;
  localparam logic [23:0]  RR_RECIP      = 24'd8589935;
  localparam logic [7:0]   BPM_MAX       = 8'd220;
  localparam logic [7:0]   BPM_MIN       = 8'd30;
  localparam logic [7:0]   FLAG_RR_PRESENT = 8'h10;
  localparam logic [7:0]   SENSOR_LOC    = 8'h05;
  localparam logic         MODE_LOW_LATENCY = 1'b0;
  localparam logic         PROFILE_MODE_RST = 1'b1;

  typedef enum logic [1:0] {
    REQ_BEAT      = 2'd0,
    REQ_FLUSH     = 2'd1,
    REQ_READ_MEAS = 2'd2,
    REQ_READ_LOC  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    SEL_FLAGS  = 3'd0,
    SEL_BPM    = 3'd1,
    SEL_ZERO   = 3'd2,
    SEL_LOC    = 3'd3,
    SEL_MEM_LO = 3'd4,
    SEL_MEM_HI = 3'd5,
    SEL_NEW_LO = 3'd6,
    SEL_NEW_HI = 3'd7
  } byte_sel_e;

  typedef struct packed {
    logic      capture;
    logic      div_start;
    logic      div_step;
    logic      bpm_update;
    logic      store_wr;
    logic      cnt_clear;
    logic      idx_clear;
    logic      idx_inc;
    logic      mem_rd;
    logic      out_load;
    byte_sel_e byte_sel;
    logic      out_last;
    logic      out_rd;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic ibi_zero;
    logic sub;
    logic mode;
    logic cnt_empty;
    logic full_next;
    logic div_last;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/hrm_dp.sv =====
module hrm_dp #(
  parameter int unsigned BATCH_DEPTH = hrm_pkg::BATCH_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hrm_pkg::cmd_t                cmd_i,
  output hrm_pkg::status_t             status_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_profile_mode_i,
  input  logic [1:0]                   req_type_i,
  input  logic [hrm_pkg::IBI_W-1:0]    ibi_ms_i,
  input  logic                         subscribed_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [hrm_pkg::BYTE_W-1:0]   out_byte_o,
  output logic                         last_byte_o,
  output logic                         is_read_reply_o
);
  import hrm_pkg::*;

  localparam int unsigned CNT_W = $clog2(BATCH_DEPTH + 1);
  localparam int unsigned IDX_W = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;

  req_e              req_q;
  logic [IBI_W-1:0]  ibi_q;
  logic              sub_q;
  logic              mode_q;

  logic [IBI_W-1:0]   rem_a_q, rem_a_d;
  logic [NUM_W-1:0]   quo_a_q;
  logic [STEP_W-1:0]  step_q;
  logic [IBI_W:0]     sh_a;
  logic               ge_a;

  logic [RR_NUM_W-1:0]  rr_num;
  logic [RR_PROD_W-1:0] rr_prod;
  logic [RR_W-1:0]      rr_d, rr_q;

  logic [BYTE_W-1:0]  last_bpm_q;
  logic [BYTE_W-1:0]  bpm_clamp;

  logic [CNT_W-1:0]   cnt_q;
  logic [IDX_W-1:0]   idx_q;
  logic [RR_W-1:0]    mem [BATCH_DEPTH];
  logic [RR_W-1:0]    rd_data_q;

  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_byte_q, byte_d;
  logic               out_last_q, out_rd_q;

  // request capture and profile register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_e'(req_type_i);
      ibi_q <= ibi_ms_i;
      sub_q <= subscribed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= PROFILE_MODE_RST;
    end else if (cfg_we_i) begin
      mode_q <= cfg_profile_mode_i;
    end
  end

  // restoring BPM divider, one quotient bit per cycle
  always_comb begin
    sh_a    = {rem_a_q, quo_a_q[NUM_W-1]};
    ge_a    = sh_a >= {1'b0, ibi_q};
    rem_a_d = ge_a ? IBI_W'(sh_a - {1'b0, ibi_q}) : sh_a[IBI_W-1:0];
  end

  // R-R in 1/1024 s: reciprocal multiply, saturated to 16 bits
  always_comb begin
    rr_num  = {ibi_q, 7'd0} + RR_ROUND_Q;
    rr_prod = {{RR_RECIP_W{1'b0}}, rr_num} * {{RR_NUM_W{1'b0}}, RR_RECIP};
    rr_d    = rr_prod[RR_PROD_W-1] ? {RR_W{1'b1}} : rr_prod[RR_SHIFT +: RR_W];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_a_q <= '0;
      quo_a_q <= NUM_W'(MS_PER_MIN + 17'(ibi_q >> 1));
      rr_q    <= rr_d;
      step_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_a_q <= rem_a_d;
      quo_a_q <= {quo_a_q[NUM_W-2:0], ge_a};
      step_q  <= step_q + 1'b1;
    end
  end

  always_comb begin
    if (quo_a_q > NUM_W'(BPM_MAX)) begin
      bpm_clamp = BPM_MAX;
    end else if (quo_a_q < NUM_W'(BPM_MIN)) begin
      bpm_clamp = BPM_MIN;
    end else begin
      bpm_clamp = quo_a_q[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_bpm_q <= '0;
      cnt_q      <= '0;
      idx_q      <= '0;
    end else begin
      if (cmd_i.bpm_update) begin
        last_bpm_q <= bpm_clamp;
      end
      if (cmd_i.cnt_clear) begin
        cnt_q <= '0;
      end else if (cmd_i.store_wr) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.idx_clear) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // R-R store
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      mem[cnt_q[IDX_W-1:0]] <= rr_q;
    end
    if (cmd_i.mem_rd) begin
      rd_data_q <= mem[idx_q];
    end
  end

  always_comb begin
    unique case (cmd_i.byte_sel)
      SEL_FLAGS:  byte_d = FLAG_RR_PRESENT;
      SEL_BPM:    byte_d = last_bpm_q;
      SEL_ZERO:   byte_d = '0;
      SEL_LOC:    byte_d = SENSOR_LOC;
      SEL_MEM_LO: byte_d = rd_data_q[7:0];
      SEL_MEM_HI: byte_d = rd_data_q[15:8];
      SEL_NEW_LO: byte_d = rr_q[7:0];
      SEL_NEW_HI: byte_d = rr_q[15:8];
      default:    byte_d = '0;
    endcase
  end

  // output register; loaded only when empty or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_q <= byte_d;
      out_last_q <= cmd_i.out_last;
      out_rd_q   <= cmd_i.out_rd;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign last_byte_o     = out_last_q;
  assign is_read_reply_o = out_rd_q;

  always_comb begin
    status_o.req       = req_q;
    status_o.ibi_zero  = (ibi_q == '0);
    status_o.sub       = sub_q;
    status_o.mode      = mode_q;
    status_o.cnt_empty = (cnt_q == '0);
    status_o.full_next = ({1'b0, cnt_q} + 1'b1) >= (CNT_W + 1)'(BATCH_DEPTH);
    status_o.div_last  = (step_q == STEP_W'(NUM_W - 1));
    status_o.idx_last  = (CNT_W'(idx_q) + 1'b1) == cnt_q;
    status_o.out_free  = !out_valid_q || !out_stall_i;
  end

endmodule

// ===== rtl/hrm_ctrl.sv =====
module hrm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  hrm_pkg::status_t status_i,
  output hrm_pkg::cmd_t    cmd_o
);
  import hrm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_POST,
    S_N_FLAGS,
    S_N_BPM,
    S_N_ONE_LO,
    S_N_ONE_HI,
    S_N_RD,
    S_N_LO,
    S_N_HI,
    S_R_ZERO,
    S_R_BPM,
    S_R_LOC
  } state_e;

  state_e state_q, state_d;
  logic   single_q, single_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      single_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      single_q <= single_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d  = state_q;
    single_d = single_q;
    cmd_o    = '0;
    cmd_o.byte_sel = SEL_ZERO;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.req)
          REQ_BEAT: begin
            if (status_i.ibi_zero) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end
          end
          REQ_FLUSH: begin
            if (status_i.cnt_empty || !status_i.sub) begin
              cmd_o.cnt_clear = 1'b1;
              state_d         = S_IDLE;
            end else begin
              single_d = 1'b0;
              state_d  = S_N_FLAGS;
            end
          end
          REQ_READ_MEAS: state_d = S_R_ZERO;
          REQ_READ_LOC:  state_d = S_R_LOC;
          default:       state_d = S_IDLE;
        endcase
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_POST;
        end
      end
      S_POST: begin
        cmd_o.bpm_update = 1'b1;
        if (!status_i.sub) begin
          state_d = S_IDLE;
        end else if (status_i.mode == MODE_LOW_LATENCY) begin
          single_d = 1'b1;
          state_d  = S_N_FLAGS;
        end else begin
          cmd_o.store_wr = 1'b1;
          single_d       = 1'b0;
          // the beat that fills the store sends the whole batch
          state_d        = status_i.full_next ? S_N_FLAGS : S_IDLE;
        end
      end
      S_N_FLAGS: begin
        cmd_o.byte_sel = SEL_FLAGS;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_N_BPM;
        end
      end
      S_N_BPM: begin
        cmd_o.byte_sel = SEL_BPM;
        if (status_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.idx_clear = 1'b1;
          state_d         = single_q ? S_N_ONE_LO : S_N_RD;
        end
      end
      S_N_ONE_LO: begin
        cmd_o.byte_sel = SEL_NEW_LO;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_N_ONE_HI;
        end
      end
      S_N_ONE_HI: begin
        cmd_o.byte_sel = SEL_NEW_HI;
        cmd_o.out_last = 1'b1;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_N_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_N_LO;
      end
      S_N_LO: begin
        cmd_o.byte_sel = SEL_MEM_LO;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_N_HI;
        end
      end
      S_N_HI: begin
        cmd_o.byte_sel = SEL_MEM_HI;
        cmd_o.out_last = status_i.idx_last;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.idx_last) begin
            cmd_o.cnt_clear = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_N_RD;
          end
        end
      end
      S_R_ZERO: begin
        cmd_o.byte_sel = SEL_ZERO;
        cmd_o.out_rd   = 1'b1;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_R_BPM;
        end
      end
      S_R_BPM: begin
        cmd_o.byte_sel = SEL_BPM;
        cmd_o.out_rd   = 1'b1;
        cmd_o.out_last = 1'b1;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_R_LOC: begin
        cmd_o.byte_sel = SEL_LOC;
        cmd_o.out_rd   = 1'b1;
        cmd_o.out_last = 1'b1;
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/heart_rate_measurement_packer.sv =====
// One request in flight at a time. Beat: accept, decode, bit-serial divide
// (one BPM quotient bit per cycle), BPM update; a low-latency notification then
// sends four bytes. Batch notification: 2 header bytes, then a store read and
// two bytes per stored R-R value. A measurement read sends two bytes, a
// location read one; a flush with nothing to send only clears the count.
// Reset: asynchronous, active low; clears control, count, last BPM, profile = batch.
module heart_rate_measurement_packer #(
  parameter int unsigned BATCH_DEPTH = hrm_pkg::BATCH_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_profile_mode_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 req_type_i,
  input  logic [hrm_pkg::IBI_W-1:0]  ibi_ms_i,
  input  logic                       subscribed_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [hrm_pkg::BYTE_W-1:0] out_byte_o,
  output logic                       last_byte_o,
  output logic                       is_read_reply_o
);
  import hrm_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  hrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hrm_dp #(
    .BATCH_DEPTH (BATCH_DEPTH)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_profile_mode_i (cfg_profile_mode_i),
    .req_type_i         (req_type_i),
    .ibi_ms_i           (ibi_ms_i),
    .subscribed_i       (subscribed_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .out_byte_o         (out_byte_o),
    .last_byte_o        (last_byte_o),
    .is_read_reply_o    (is_read_reply_o)
  );

endmodule

// ===== rtl/hrm_chk.sv =====
module hrm_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       last_byte_o,
  input logic       is_read_reply_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(last_byte_o) && $stable(is_read_reply_o))
    else $error("stalled result changed");

  // one request at a time: busy right after an accept
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one in flight");

  // only the leading byte of a measurement read is not last, and it is zero
  a_read_lead_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_read_reply_o && !last_byte_o |-> out_byte_o == 8'h00)
    else $error("bad leading read reply byte");

  // a drained leading read-reply byte is followed by the reply's last byte or idle output
  a_read_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && is_read_reply_o && !last_byte_o
      |=> !out_valid_o || (is_read_reply_o && last_byte_o))
    else $error("read reply not finished by its second byte");

endmodule

bind heart_rate_measurement_packer hrm_chk u_hrm_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_byte_o      (out_byte_o),
  .last_byte_o     (last_byte_o),
  .is_read_reply_o (is_read_reply_o)
);
